// ===== hw/rtl/ocsg_pkg.sv =====
// Shared types, register codes and constants of the obstacle clearance speed governor.
`default_nettype none

package ocsg_pkg;

  localparam int unsigned DIST_W     = 16;
  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned VC_W       = 7;
  localparam int unsigned REC_W      = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned WINDOW_DEPTH_DEF    = 8;
  localparam int unsigned PRIMITIVE_COUNT_DEF = 64;

  // distance code meaning "no obstacle"
  localparam logic [DIST_W-1:0] DIST_NONE = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DETECT_DIST  = 3'd0,
    REG_RELEASE_DIST = 3'd1,
    REG_MIN_CLEAR    = 3'd2,
    REG_RAMP_INV     = 3'd3,
    REG_REC_CYCLES   = 3'd4,
    REG_MIN_SPEED    = 3'd5,
    REG_MAX_SPEED    = 3'd6,
    REG_REC_CAP      = 3'd7
  } cfg_reg_e;

  localparam logic [DIST_W-1:0]  DETECT_DIST_RST  = 16'd512;
  localparam logic [DIST_W-1:0]  RELEASE_DIST_RST = 16'd640;
  localparam logic [DIST_W-1:0]  MIN_CLEAR_RST    = 16'd128;
  localparam logic [15:0]        RAMP_INV_RST     = 16'd171;
  localparam logic [REC_W-1:0]   REC_CYCLES_RST   = 10'd20;
  localparam logic [SPEED_W-1:0] MIN_SPEED_RST    = 16'd1229;
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST    = 16'd6144;
  localparam logic [SPEED_W-1:0] REC_CAP_RST      = 16'd2048;

  typedef struct packed {
    logic [DIST_W-1:0] raw_closest_distance;
    logic [VC_W-1:0]   valid_count;
  } in_t;

  typedef struct packed {
    logic [DIST_W-1:0]  filtered_distance;
    logic               avoiding;
    logic               estop;
    logic               recovery_active;
    logic [SPEED_W-1:0] speed;
  } out_t;

  typedef struct packed {
    logic accept;
    logic scan_en;
    logic eval;
    logic mul1;
    logic mul2;
    logic mul3;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic div_done;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ocsg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ocsg_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ocsg_ctrl.sv =====
// Sequencer of the speed governor: steps the datapath through scan, evaluate and multiply.
`default_nettype none

module ocsg_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  input  wire ocsg_pkg::dp_status_t   status_i,
  output ocsg_pkg::ctrl_cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EVAL,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_DONE
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = in_valid_i && in_ready_q;
    cmd_o.scan_en  = (state_q == ST_SCAN);
    cmd_o.eval     = (state_q == ST_EVAL);
    cmd_o.mul1     = (state_q == ST_MUL1);
    cmd_o.mul2     = (state_q == ST_MUL2);
    cmd_o.mul3     = (state_q == ST_MUL3);
    // result register must be free (or drained this cycle) and the quotient settled
    cmd_o.out_load = (state_q == ST_DONE) && status_i.div_done &&
                     (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_o.accept) begin
            state_q    <= ST_SCAN;
            in_ready_q <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (status_i.scan_last) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: state_q <= ST_EVAL;
        ST_EVAL:  state_q <= ST_MUL1;
        ST_MUL1:  state_q <= ST_MUL2;
        ST_MUL2:  state_q <= ST_MUL3;
        ST_MUL3:  state_q <= ST_DONE;
        ST_DONE: begin
          if (cmd_o.out_load) begin
            state_q    <= ST_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_q) |=> !in_ready_q)
    else $error("request taken while previous one still in work");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before it was taken");

  a_load_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> status_i.div_done)
    else $error("result loaded before density quotient finished");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/ocsg_datapath.sv =====
// Datapath of the speed governor: config registers, distance window, min scan and speed math.
`default_nettype none

module ocsg_datapath #(
  parameter int unsigned WINDOW_DEPTH    = ocsg_pkg::WINDOW_DEPTH_DEF,
  parameter int unsigned PRIMITIVE_COUNT = ocsg_pkg::PRIMITIVE_COUNT_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [ocsg_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [ocsg_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  wire ocsg_pkg::in_t                       in_data_i,
  input  wire ocsg_pkg::ctrl_cmd_t                 cmd_i,
  output ocsg_pkg::dp_status_t                     status_o,
  output ocsg_pkg::out_t                           out_data_o
);

  localparam int unsigned DW    = ocsg_pkg::DIST_W;
  localparam int unsigned SW    = ocsg_pkg::SPEED_W;
  localparam int unsigned RW    = ocsg_pkg::REC_W;
  localparam int unsigned AW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned PC_W  = $clog2(PRIMITIVE_COUNT + 1);
  localparam int unsigned CMP_W = (PC_W > ocsg_pkg::VC_W) ? PC_W : ocsg_pkg::VC_W;
  localparam int unsigned X_W   = SW + PC_W;
  localparam int unsigned PC_LOG = $clog2(PRIMITIVE_COUNT);
  localparam int unsigned RSH   = X_W + PC_LOG;
  localparam int unsigned RC_W  = X_W + 1;
  // ceil(2^RSH / PRIMITIVE_COUNT): exact floor quotient for any X_W-bit dividend
  localparam longint unsigned RECIP_L =
    ((64'd1 << RSH) + 64'(PRIMITIVE_COUNT) - 64'd1) / 64'(PRIMITIVE_COUNT);

  localparam logic [AW-1:0]    LAST_ADDR = AW'(WINDOW_DEPTH - 1);
  localparam logic [CMP_W-1:0] PC_CMP    = CMP_W'(PRIMITIVE_COUNT);
  localparam logic [X_W-1:0]   HALF_PC   = X_W'(PRIMITIVE_COUNT / 2);
  localparam logic [RC_W-1:0]  RECIP     = RC_W'(RECIP_L);
  localparam logic [16:0]      T_ONE     = 17'h10000;

  // configuration registers
  logic [DW-1:0] detect_q, release_q, minclr_q;
  logic [15:0]   ramp_q;
  logic [RW-1:0] rec_cycles_q;
  logic [SW-1:0] min_speed_q, max_speed_q, rec_cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detect_q     <= ocsg_pkg::DETECT_DIST_RST;
      release_q    <= ocsg_pkg::RELEASE_DIST_RST;
      minclr_q     <= ocsg_pkg::MIN_CLEAR_RST;
      ramp_q       <= ocsg_pkg::RAMP_INV_RST;
      rec_cycles_q <= ocsg_pkg::REC_CYCLES_RST;
      min_speed_q  <= ocsg_pkg::MIN_SPEED_RST;
      max_speed_q  <= ocsg_pkg::MAX_SPEED_RST;
      rec_cap_q    <= ocsg_pkg::REC_CAP_RST;
    end else if (cfg_we_i) begin
      unique case (ocsg_pkg::cfg_reg_e'(cfg_idx_i))
        ocsg_pkg::REG_DETECT_DIST:  detect_q     <= cfg_wdata_i;
        ocsg_pkg::REG_RELEASE_DIST: release_q    <= cfg_wdata_i;
        ocsg_pkg::REG_MIN_CLEAR:    minclr_q     <= cfg_wdata_i;
        ocsg_pkg::REG_RAMP_INV:     ramp_q       <= cfg_wdata_i;
        ocsg_pkg::REG_REC_CYCLES:   rec_cycles_q <= cfg_wdata_i[RW-1:0];
        ocsg_pkg::REG_MIN_SPEED:    min_speed_q  <= cfg_wdata_i;
        ocsg_pkg::REG_MAX_SPEED:    max_speed_q  <= cfg_wdata_i;
        ocsg_pkg::REG_REC_CAP:      rec_cap_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- window
  logic [AW-1:0]           wptr_q;
  logic [AW-1:0]           scan_addr_q;
  logic [WINDOW_DEPTH-1:0] wvalid_q;
  logic                    rd_pend_q;
  logic                    rd_vld_q;
  logic [DW-1:0]           rdata;
  logic [DW-1:0]           cand;
  logic [DW-1:0]           min_q;

  ocsg_ram #(
    .WIDTH (DW),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept),
    .waddr_i (wptr_q),
    .wdata_i (in_data_i.raw_closest_distance),
    .re_i    (cmd_i.scan_en),
    .raddr_i (scan_addr_q),
    .rdata_o (rdata)
  );

  // entries never written read as "no obstacle"
  assign cand = rd_vld_q ? rdata : ocsg_pkg::DIST_NONE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q      <= '0;
      scan_addr_q <= '0;
      wvalid_q    <= '0;
      rd_pend_q   <= 1'b0;
      rd_vld_q    <= 1'b0;
      min_q       <= ocsg_pkg::DIST_NONE;
    end else begin
      rd_pend_q <= cmd_i.scan_en;
      if (cmd_i.accept) begin
        wvalid_q[wptr_q] <= 1'b1;
        wptr_q           <= (wptr_q == LAST_ADDR) ? '0 : wptr_q + AW'(1);
        scan_addr_q      <= '0;
        min_q            <= ocsg_pkg::DIST_NONE;
      end
      if (cmd_i.scan_en) begin
        rd_vld_q    <= wvalid_q[scan_addr_q];
        scan_addr_q <= (scan_addr_q == LAST_ADDR) ? '0 : scan_addr_q + AW'(1);
      end
      if (rd_pend_q && (cand < min_q)) begin
        min_q <= cand;
      end
    end
  end

  // ------------------------------------------------- density ramp quotient
  logic [CMP_W-1:0]      vc_ext, vc_clip;
  logic [PC_W-1:0]       vc_sat;
  logic                  sv_up;
  logic [SW-1:0]         sv_diff;
  logic [X_W-1:0]        dv_prod;
  logic [X_W-1:0]        dividend;
  logic [X_W-1:0]        x_q;
  logic [X_W+RC_W-1:0]   q_prod;
  logic [SW-1:0]         quot_q;
  logic                  div_busy_q;
  logic                  vc_nz_q;

  assign vc_ext   = CMP_W'(in_data_i.valid_count);
  assign vc_clip  = (vc_ext > PC_CMP) ? PC_CMP : vc_ext;
  assign vc_sat   = vc_clip[PC_W-1:0];
  assign sv_up    = (max_speed_q >= min_speed_q);
  assign sv_diff  = sv_up ? (max_speed_q - min_speed_q) : (min_speed_q - max_speed_q);
  assign dv_prod  = sv_diff * vc_sat;
  assign dividend = dv_prod + HALF_PC;

  // divide by the primitive count through a reciprocal multiply
  assign q_prod = x_q * RECIP;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      vc_nz_q    <= 1'b0;
    end else if (cmd_i.accept) begin
      div_busy_q <= 1'b1;
      vc_nz_q    <= (vc_sat != '0);
    end else begin
      div_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q <= dividend;
    end
    if (div_busy_q) begin
      quot_q <= q_prod[RSH +: SW];
    end
  end

  // ------------------------------------------- flag, e-stop and distance ramp
  logic          det_q, estop_q;
  logic [RW-1:0] rec_q;
  logic          det_n, estop_n;
  logic [RW-1:0] rec_n;
  logic [DW-1:0] gap_q;
  logic [31:0]   t_prod;
  logic [16:0]   t_q;
  logic [33:0]   t_sq;
  logic [33:0]   t_sq_rnd;
  logic [16:0]   t2_q;
  logic [SW-1:0] top;
  logic          sd_up_q;
  logic [SW-1:0] sd_diff_q;
  logic [32:0]   sd_prod;
  logic [32:0]   sd_rnd;
  logic [SW-1:0] sd_q;
  logic [SW-1:0] sv;
  logic [SW-1:0] speed;
  ocsg_pkg::out_t out_q;

  assign det_n   = (min_q < detect_q) || (det_q && (min_q < release_q));
  assign estop_n = (min_q < minclr_q);
  assign rec_n   = estop_n ? rec_cycles_q :
                   ((rec_q != '0) ? rec_q - RW'(1) : rec_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_q   <= 1'b0;
      estop_q <= 1'b0;
      rec_q   <= '0;
    end else if (cmd_i.eval) begin
      det_q   <= det_n;
      estop_q <= estop_n;
      rec_q   <= rec_n;
    end
  end

  assign t_prod   = gap_q * ramp_q;
  assign t_sq     = t_q * t_q;
  assign t_sq_rnd = t_sq + 34'd32768;
  assign top      = (rec_q != '0) ? rec_cap_q : max_speed_q;
  assign sd_prod  = sd_diff_q * t2_q;
  assign sd_rnd   = sd_prod + 33'd32768;

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      gap_q <= min_q - minclr_q;
    end
    if (cmd_i.mul1) begin
      t_q <= (t_prod > 32'(T_ONE)) ? T_ONE : t_prod[16:0];
    end
    if (cmd_i.mul2) begin
      t2_q      <= t_sq_rnd[32:16];
      sd_up_q   <= (top >= min_speed_q);
      sd_diff_q <= (top >= min_speed_q) ? (top - min_speed_q) : (min_speed_q - top);
    end
    if (cmd_i.mul3) begin
      sd_q <= sd_up_q ? (min_speed_q + sd_rnd[31:16]) : (min_speed_q - sd_rnd[31:16]);
    end
  end

  assign sv     = sv_up ? (min_speed_q + quot_q) : (min_speed_q - quot_q);
  assign speed  = (estop_q || !vc_nz_q) ? '0 : ((sd_q < sv) ? sd_q : sv);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.filtered_distance <= min_q;
      out_q.avoiding          <= det_q;
      out_q.estop             <= estop_q;
      out_q.recovery_active   <= (rec_q != '0);
      out_q.speed             <= speed;
    end
  end

  assign out_data_o         = out_q;
  assign status_o.scan_last = (scan_addr_q == LAST_ADDR);
  assign status_o.div_done  = !div_busy_q;

`ifndef NO_ASSERTIONS
  a_estop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && estop_q) |=> (out_q.speed == '0))
    else $error("nonzero speed delivered with e-stop set");

  a_rec_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> (out_q.recovery_active == (rec_q != '0)))
    else $error("recovery flag disagrees with recovery counter");

  a_wptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wptr_q <= LAST_ADDR)
    else $error("window write pointer out of range");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/obstacle_clearance_speed_governor.sv =====
// Top level of the obstacle clearance speed governor.
`default_nettype none

// Takes one request per planning cycle (closest obstacle distance, count of free
// primitives) and returns one result: the minimum over the last WINDOW_DEPTH
// distances, the hysteresis obstacle flag, e-stop, recovery status and the
// commanded speed. From acceptance until the next request can be taken, the
// window is swept one entry per cycle through the single read port of the
// window RAM, then come a drain step, the flag and e-stop update, the
// three-multiply distance ramp and the result load. The density ramp quotient
// is formed by a reciprocal multiply in the cycle after acceptance and never
// sets the pace. The result load waits while the previous result is still
// held in the output register. A finished result sits in the output register
// while the next request is accepted. Configuration registers are written
// through cfg_we_i / cfg_idx_i / cfg_wdata_i and must only change while no
// request is in flight.
module obstacle_clearance_speed_governor #(
  parameter int unsigned WINDOW_DEPTH    = ocsg_pkg::WINDOW_DEPTH_DEF,
  parameter int unsigned PRIMITIVE_COUNT = ocsg_pkg::PRIMITIVE_COUNT_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [ocsg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ocsg_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire ocsg_pkg::in_t                   in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output ocsg_pkg::out_t                       out_data_o
);

  ocsg_pkg::ctrl_cmd_t  cmd;
  ocsg_pkg::dp_status_t status;

  ocsg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ocsg_datapath #(
    .WINDOW_DEPTH    (WINDOW_DEPTH),
    .PRIMITIVE_COUNT (PRIMITIVE_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== test/tb_obstacle_clearance_speed_governor.sv =====
// Self-checking testbench for the obstacle clearance speed governor.
`timescale 1ns / 100ps

module tb_obstacle_clearance_speed_governor;

  localparam int WIN_N = ocsg_pkg::WINDOW_DEPTH_DEF;
  localparam int PRIM_N = ocsg_pkg::PRIMITIVE_COUNT_DEF;
  localparam int REC_N = ocsg_pkg::REC_W;
  localparam int HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES = 64;
  localparam int ITEMS_PER_PHASE = 90;

  // request styles of the random part
  localparam int STY_NOISE = 0;
  localparam int STY_EXTREME = 1;
  localparam int STY_WALK = 2;

  // register settings per phase
  localparam int KIND_DEFAULT = 0;
  localparam int KIND_TOP = 1;
  localparam int KIND_ZERO = 2;
  localparam int KIND_CROSSED = 3;
  localparam int KIND_RANDOM = 4;
  localparam int PHASE_KIND [8] = '{KIND_RANDOM, KIND_TOP, KIND_RANDOM, KIND_ZERO,
                                    KIND_CROSSED, KIND_RANDOM, KIND_DEFAULT, KIND_RANDOM};
  localparam int PRESSURE_PHASE = 2;

  typedef struct packed {
    ocsg_pkg::in_t  req;
    logic           typed;
    ocsg_pkg::out_t want;
  } dir_row_t;

  localparam ocsg_pkg::out_t NO_WANT = '0;
  localparam ocsg_pkg::out_t WANT_CLEAR = {ocsg_pkg::DIST_NONE, 1'b0, 1'b0, 1'b0,
                                           ocsg_pkg::MAX_SPEED_RST};
  localparam ocsg_pkg::out_t WANT_STOP = {16'h0000, 1'b1, 1'b1, 1'b1, 16'd0};
  localparam int DIR_N = 22;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [ocsg_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [ocsg_pkg::CFG_DATA_W-1:0] cfg_wdata_i;
  logic                            in_valid_i;
  logic                            in_ready_o;
  ocsg_pkg::in_t                   in_data_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  ocsg_pkg::out_t                  out_data_o;

  // governor state mirrored by the testbench
  logic [15:0]      cfg_q [8];
  logic [15:0]      cfg_rst [8];
  logic [15:0]      win_mem [WIN_N];
  int               win_ptr;
  logic             avoid_flag;
  logic [REC_N-1:0] rec_cnt;

  ocsg_pkg::out_t cmd_due_q [$];
  ocsg_pkg::out_t due_now;
  int   mism_cnt = 0;
  int   walk_dist;
  bit   hold_off_req = 1'b0;

  dir_row_t dir_tab [DIR_N] = '{
    {16'hFFFF, 7'd64,  1'b1, WANT_CLEAR},
    {16'h0000, 7'd64,  1'b1, WANT_STOP},
    {16'hFFFF, 7'd64,  1'b1, WANT_STOP},
    {16'hFFFF, 7'd0,   1'b1, WANT_STOP},
    {16'hFFFF, 7'd127, 1'b0, NO_WANT},
    {16'hFFFF, 7'd65,  1'b0, NO_WANT},
    {16'hFFFF, 7'd1,   1'b0, NO_WANT},
    {16'hFFFF, 7'd32,  1'b0, NO_WANT},
    {16'h0080, 7'd64,  1'b0, NO_WANT},
    {16'h0080, 7'd63,  1'b0, NO_WANT},
    {16'h007F, 7'd64,  1'b0, NO_WANT},
    {16'h0200, 7'd64,  1'b0, NO_WANT},
    {16'h01FF, 7'd48,  1'b0, NO_WANT},
    {16'h027F, 7'd64,  1'b0, NO_WANT},
    {16'h0280, 7'd64,  1'b0, NO_WANT},
    {16'h0300, 7'd16,  1'b0, NO_WANT},
    {16'h0300, 7'd64,  1'b0, NO_WANT},
    {16'h0300, 7'd64,  1'b0, NO_WANT},
    {16'h0300, 7'd64,  1'b0, NO_WANT},
    {16'h0280, 7'd64,  1'b0, NO_WANT},
    {16'h0281, 7'd64,  1'b0, NO_WANT},
    {16'hFFFF, 7'd64,  1'b0, NO_WANT}
  };

  obstacle_clearance_speed_governor i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("obstacle_clearance_speed_governor: mismatch");
    $finish;
  end

  // lo + round(num * (hi - lo) / den), end speeds in either order
  function automatic longint unsigned lerp(longint unsigned lo, longint unsigned hi,
                                           longint unsigned num, longint unsigned den);
    longint unsigned span, q;
    span = (hi >= lo) ? hi - lo : lo - hi;
    q = (span * num + den / 2) / den;
    return (hi >= lo) ? lo + q : lo - q;
  endfunction

  function automatic ocsg_pkg::out_t govern(ocsg_pkg::in_t req);
    ocsg_pkg::out_t res;
    longint unsigned vc, t, t2, top, sd, sv;
    logic [15:0] filt;
    vc = (req.valid_count > PRIM_N) ? PRIM_N : req.valid_count;
    win_mem[win_ptr] = req.raw_closest_distance;
    win_ptr = (win_ptr + 1) % WIN_N;
    filt = ocsg_pkg::DIST_NONE;
    foreach (win_mem[i]) if (win_mem[i] < filt) filt = win_mem[i];
    avoid_flag = (filt < cfg_q[ocsg_pkg::REG_DETECT_DIST]) ||
                 (avoid_flag && filt < cfg_q[ocsg_pkg::REG_RELEASE_DIST]);
    res = '0;
    res.filtered_distance = filt;
    res.avoiding = avoid_flag;
    res.estop = filt < cfg_q[ocsg_pkg::REG_MIN_CLEAR];
    if (res.estop) begin
      rec_cnt = cfg_q[ocsg_pkg::REG_REC_CYCLES][REC_N-1:0];
    end else begin
      if (rec_cnt != 0) rec_cnt--;
      if (vc != 0) begin
        t = (64'(filt) - 64'(cfg_q[ocsg_pkg::REG_MIN_CLEAR])) *
            64'(cfg_q[ocsg_pkg::REG_RAMP_INV]);
        if (t > 65536) t = 65536;
        t2 = (t * t + 32768) >> 16;
        // ramp top drops to the cap while recovering
        top = (rec_cnt != 0) ? cfg_q[ocsg_pkg::REG_REC_CAP] : cfg_q[ocsg_pkg::REG_MAX_SPEED];
        sd = lerp(cfg_q[ocsg_pkg::REG_MIN_SPEED], top, t2, 65536);
        sv = lerp(cfg_q[ocsg_pkg::REG_MIN_SPEED], cfg_q[ocsg_pkg::REG_MAX_SPEED], vc,
                  PRIM_N);
        res.speed = (sd < sv) ? sd[15:0] : sv[15:0];
      end
    end
    res.recovery_active = (rec_cnt != 0);
    return res;
  endfunction

  function automatic ocsg_pkg::in_t make_req(int style);
    ocsg_pkg::in_t req;
    int pick;
    case (style)
      STY_NOISE: begin
        req.raw_closest_distance = 16'($urandom);
        req.valid_count = 7'($urandom_range(0, 127));
      end
      STY_EXTREME: begin
        req.raw_closest_distance = $urandom_range(0, 1) ? ocsg_pkg::DIST_NONE : 16'h0000;
        pick = $urandom_range(0, 2);
        req.valid_count = (pick == 0) ? 7'd0 : (pick == 1) ? 7'(PRIM_N) : 7'd127;
      end
      default: begin
        // drifting obstacle, now and then snapped next to a threshold
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          case ($urandom_range(0, 2))
            0: walk_dist = int'(cfg_q[ocsg_pkg::REG_DETECT_DIST]);
            1: walk_dist = int'(cfg_q[ocsg_pkg::REG_RELEASE_DIST]);
            default: walk_dist = int'(cfg_q[ocsg_pkg::REG_MIN_CLEAR]);
          endcase
          walk_dist = walk_dist + int'($urandom_range(0, 16)) - 8;
        end else begin
          walk_dist = walk_dist + int'($urandom_range(0, 40)) - 20;
        end
        if (walk_dist < 0) walk_dist = 0;
        if (walk_dist > 65535) walk_dist = 65535;
        req.raw_closest_distance = (pick == 1) ? ocsg_pkg::DIST_NONE : walk_dist[15:0];
        pick = $urandom_range(0, 15);
        if (pick == 0) req.valid_count = 7'd0;
        else if (pick == 1) req.valid_count = 7'($urandom_range(PRIM_N + 1, 127));
        else req.valid_count = 7'($urandom_range(1, PRIM_N));
      end
    endcase
    return req;
  endfunction

  task automatic send_req(ocsg_pkg::in_t req, logic typed, ocsg_pkg::out_t want);
    ocsg_pkg::out_t due;
    in_valid_i <= 1'b1;
    in_data_i <= req;
    do @(posedge clk_i); while (!in_ready_o);
    due = govern(req);
    cmd_due_q = {cmd_due_q, (typed ? want : due)};
  endtask

  // drop valid and wait for every outstanding result
  task automatic settle();
    in_valid_i <= 1'b0;
    while (cmd_due_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_regs(int kind);
    logic [15:0] v [8];
    ocsg_pkg::cfg_reg_e r;
    int span;
    case (kind)
      KIND_DEFAULT: v = cfg_rst;
      KIND_TOP: begin
        foreach (v[i]) v[i] = 16'hFFFF;
        v[ocsg_pkg::REG_REC_CYCLES] = 16'd1023;
      end
      KIND_ZERO: foreach (v[i]) v[i] = 16'h0000;
      KIND_CROSSED: begin
        // detect drawn from a lower range than clearance, release at or below detect, end speeds swapped
        v[ocsg_pkg::REG_MIN_CLEAR] = 16'($urandom_range(200, 800));
        v[ocsg_pkg::REG_DETECT_DIST] = 16'($urandom_range(0, 300));
        v[ocsg_pkg::REG_RELEASE_DIST] =
          16'($urandom_range(0, v[ocsg_pkg::REG_DETECT_DIST]));
        v[ocsg_pkg::REG_RAMP_INV] = 16'($urandom);
        v[ocsg_pkg::REG_REC_CYCLES] = 16'($urandom_range(0, 1023));
        v[ocsg_pkg::REG_MIN_SPEED] = 16'($urandom_range(30000, 65535));
        v[ocsg_pkg::REG_MAX_SPEED] = 16'($urandom_range(0, 20000));
        v[ocsg_pkg::REG_REC_CAP] = 16'($urandom);
      end
      default: begin
        span = $urandom_range(1, 600);
        v[ocsg_pkg::REG_MIN_CLEAR] = 16'($urandom_range(0, 400));
        v[ocsg_pkg::REG_DETECT_DIST] = v[ocsg_pkg::REG_MIN_CLEAR] + 16'(span);
        v[ocsg_pkg::REG_RELEASE_DIST] =
          v[ocsg_pkg::REG_DETECT_DIST] + 16'($urandom_range(0, 300));
        v[ocsg_pkg::REG_RAMP_INV] = (span == 1) ? 16'hFFFF : 16'(65536 / span);
        v[ocsg_pkg::REG_REC_CYCLES] = 16'($urandom_range(0, 40));
        v[ocsg_pkg::REG_MIN_SPEED] = 16'($urandom_range(0, 4096));
        v[ocsg_pkg::REG_MAX_SPEED] =
          v[ocsg_pkg::REG_MIN_SPEED] + 16'($urandom_range(0, 20000));
        v[ocsg_pkg::REG_REC_CAP] =
          16'($urandom_range(v[ocsg_pkg::REG_MIN_SPEED], v[ocsg_pkg::REG_MAX_SPEED]));
      end
    endcase
    r = r.first();
    do begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= r;
      cfg_wdata_i <= v[r];
      @(posedge clk_i);
      cfg_q[r] = (r == ocsg_pkg::REG_REC_CYCLES) ? 16'(v[r][REC_N-1:0]) : v[r];
      r = r.next();
    end while (r != r.first());
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_items(int n);
    int sent, burst, r, style;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 12);
      r = $urandom_range(0, 9);
      style = (r < 2) ? STY_NOISE : (r < 3) ? STY_EXTREME : STY_WALK;
      while (burst > 0 && sent < n) begin
        send_req(make_req(style), 1'b0, NO_WANT);
        sent++;
        burst--;
      end
      if (sent < n && $urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
  endtask

  // receiver: stall patterns that change every so often, plus the long hold-off
  initial begin
    int mode, per, cnt, left;
    out_ready_i = 1'b0;
    mode = 0;
    per = 2;
    cnt = 0;
    left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
        out_ready_i <= 1'b1;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          per = $urandom_range(2, 6);
          left = $urandom_range(20, 150);
        end
        left--;
        cnt++;
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ((cnt % per) == 0);
          default: out_ready_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic flag_field(string what, longint unsigned want, longint unsigned got);
    if (want != got) begin
      mism_cnt++;
      $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cmd_due_q.size() == 0) begin
        mism_cnt++;
        $display("%0t: result without request, expected none, actual %h",
                 $time, out_data_o);
      end else begin
        due_now = cmd_due_q.pop_front();
        flag_field("filtered_distance", due_now.filtered_distance,
                   out_data_o.filtered_distance);
        flag_field("avoiding", due_now.avoiding, out_data_o.avoiding);
        flag_field("estop", due_now.estop, out_data_o.estop);
        flag_field("recovery_active", due_now.recovery_active, out_data_o.recovery_active);
        flag_field("speed", due_now.speed, out_data_o.speed);
      end
    end
  end

  initial begin
    cfg_we_i = 1'b0;
    cfg_idx_i = ocsg_pkg::REG_DETECT_DIST;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    rst_ni = 1'b0;
    cfg_rst[ocsg_pkg::REG_DETECT_DIST] = ocsg_pkg::DETECT_DIST_RST;
    cfg_rst[ocsg_pkg::REG_RELEASE_DIST] = ocsg_pkg::RELEASE_DIST_RST;
    cfg_rst[ocsg_pkg::REG_MIN_CLEAR] = ocsg_pkg::MIN_CLEAR_RST;
    cfg_rst[ocsg_pkg::REG_RAMP_INV] = ocsg_pkg::RAMP_INV_RST;
    cfg_rst[ocsg_pkg::REG_REC_CYCLES] = 16'(ocsg_pkg::REC_CYCLES_RST);
    cfg_rst[ocsg_pkg::REG_MIN_SPEED] = ocsg_pkg::MIN_SPEED_RST;
    cfg_rst[ocsg_pkg::REG_MAX_SPEED] = ocsg_pkg::MAX_SPEED_RST;
    cfg_rst[ocsg_pkg::REG_REC_CAP] = ocsg_pkg::REC_CAP_RST;
    cfg_q = cfg_rst;
    foreach (win_mem[i]) win_mem[i] = ocsg_pkg::DIST_NONE;
    win_ptr = 0;
    avoid_flag = 1'b0;
    rec_cnt = '0;
    walk_dist = 1000;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[k]) begin
      send_req(dir_tab[k].req, dir_tab[k].typed, dir_tab[k].want);
      if (k != DIR_N - 1 && $urandom_range(0, 2) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
    settle();

    foreach (PHASE_KIND[p]) begin
      program_regs(PHASE_KIND[p]);
      if (p == PRESSURE_PHASE) begin
        // output blocked while requests keep coming: input must back up
        hold_off_req = 1'b1;
        repeat (8) send_req(make_req(STY_WALK), 1'b0, NO_WANT);
        settle();
      end
      run_items(ITEMS_PER_PHASE);
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mism_cnt == 0 && cmd_due_q.size() == 0) begin
      $display("obstacle_clearance_speed_governor: match");
    end else begin
      $display("obstacle_clearance_speed_governor: mismatch");
    end
    $finish;
  end

endmodule
